FILE: rtl/core/ppm_pkg.sv
package ppm_pkg;

    localparam int unsigned RAW_W  = 16;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned CFG_W  = 32;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned FLT_W  = 4;

    localparam logic [IDX_W-1:0] REG_ACCEL_A_WINDOW     = 3'd0;
    localparam logic [IDX_W-1:0] REG_ACCEL_B_WINDOW     = 3'd1;
    localparam logic [IDX_W-1:0] REG_BRAKE_FRONT_WINDOW = 3'd2;
    localparam logic [IDX_W-1:0] REG_BRAKE_REAR_WINDOW  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DISAGREE_LIMIT     = 3'd4;
    localparam logic [IDX_W-1:0] REG_ABUSE_THRESHOLDS   = 3'd5;
    localparam logic [IDX_W-1:0] REG_ABUSE_CHECK_ON     = 3'd6;
    localparam logic [IDX_W-1:0] REG_PERSIST_LIMIT      = 3'd7;

    localparam logic [CFG_W-1:0] WINDOW_RST        = 32'hFFFF_0000;
    localparam logic [RAW_W-1:0] DISAGREE_RST      = 16'hFFFF;
    localparam logic [CFG_W-1:0] ABUSE_THRESH_RST  = 32'hFFFF_FFFF;
    localparam logic             ABUSE_ON_RST      = 1'b0;
    localparam logic [CNT_W-1:0] PERSIST_RST       = 16'd10;

    localparam int unsigned FLT_ACCEL_RANGE = 0;
    localparam int unsigned FLT_ACCEL_DIFF  = 1;
    localparam int unsigned FLT_BRAKE_RANGE = 2;
    localparam int unsigned FLT_ABUSE       = 3;

    typedef struct packed {
        logic [RAW_W-1:0] accel_raw_a;
        logic [RAW_W-1:0] accel_raw_b;
        logic [RAW_W-1:0] accel_pos_a;
        logic [RAW_W-1:0] accel_pos_b;
        logic [RAW_W-1:0] brake_raw_front;
        logic [RAW_W-1:0] brake_raw_rear;
        logic [RAW_W-1:0] accel_pos;
        logic [RAW_W-1:0] brake_pres_front;
    } sample_t;

    typedef struct packed {
        logic [FLT_W-1:0] fault_flags;
        logic             fault_status;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] accel_a_window;
        logic [CFG_W-1:0] accel_b_window;
        logic [CFG_W-1:0] brake_front_window;
        logic [CFG_W-1:0] brake_rear_window;
        logic [RAW_W-1:0] disagree_limit;
        logic [CFG_W-1:0] abuse_thresholds;
        logic             abuse_check_on;
        logic [CNT_W-1:0] persist_limit;
    } cfg_t;

    typedef struct packed {
        logic accel_range;
        logic accel_diff;
        logic brake_range;
        logic abuse;
    } cond_t;

    function automatic logic outside(logic [RAW_W-1:0] v, logic [CFG_W-1:0] win);
        logic [RAW_W-1:0] upper;
        logic [RAW_W-1:0] lower;
        upper = win[CFG_W-1:RAW_W];
        lower = win[RAW_W-1:0];
        return (v > upper) || (v < lower);
    endfunction

endpackage

FILE: rtl/core/ppm_cfg_regs.sv
module ppm_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ppm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ppm_pkg::CFG_W-1:0]   cfg_data,
    output ppm_pkg::cfg_t               cfg
);

    ppm_pkg::cfg_t cfg_reg;
    ppm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ppm_pkg::REG_ACCEL_A_WINDOW:     cfg_next.accel_a_window = cfg_data;
                ppm_pkg::REG_ACCEL_B_WINDOW:     cfg_next.accel_b_window = cfg_data;
                ppm_pkg::REG_BRAKE_FRONT_WINDOW: cfg_next.brake_front_window = cfg_data;
                ppm_pkg::REG_BRAKE_REAR_WINDOW:  cfg_next.brake_rear_window = cfg_data;
                ppm_pkg::REG_DISAGREE_LIMIT:
                    cfg_next.disagree_limit = cfg_data[ppm_pkg::RAW_W-1:0];
                ppm_pkg::REG_ABUSE_THRESHOLDS:   cfg_next.abuse_thresholds = cfg_data;
                ppm_pkg::REG_ABUSE_CHECK_ON:     cfg_next.abuse_check_on = cfg_data[0];
                ppm_pkg::REG_PERSIST_LIMIT:
                    cfg_next.persist_limit = cfg_data[ppm_pkg::CNT_W-1:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_a_window     <= ppm_pkg::WINDOW_RST;
            cfg_reg.accel_b_window     <= ppm_pkg::WINDOW_RST;
            cfg_reg.brake_front_window <= ppm_pkg::WINDOW_RST;
            cfg_reg.brake_rear_window  <= ppm_pkg::WINDOW_RST;
            cfg_reg.disagree_limit     <= ppm_pkg::DISAGREE_RST;
            cfg_reg.abuse_thresholds   <= ppm_pkg::ABUSE_THRESH_RST;
            cfg_reg.abuse_check_on     <= ppm_pkg::ABUSE_ON_RST;
            cfg_reg.persist_limit      <= ppm_pkg::PERSIST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/ppm_check.sv
module ppm_check (
    input  ppm_pkg::sample_t smp,
    input  ppm_pkg::cfg_t    cfg,
    output ppm_pkg::cond_t   cond
);

    logic [ppm_pkg::RAW_W-1:0] diff;

    always_comb
    begin
        if (smp.accel_pos_a > smp.accel_pos_b)
        begin
            diff = smp.accel_pos_a - smp.accel_pos_b;
        end
        else
        begin
            diff = smp.accel_pos_b - smp.accel_pos_a;
        end

        cond.accel_range = ppm_pkg::outside(smp.accel_raw_a, cfg.accel_a_window)
                        || ppm_pkg::outside(smp.accel_raw_b, cfg.accel_b_window);
        cond.accel_diff  = diff > cfg.disagree_limit;
        cond.brake_range = ppm_pkg::outside(smp.brake_raw_front, cfg.brake_front_window)
                        || ppm_pkg::outside(smp.brake_raw_rear, cfg.brake_rear_window);
        cond.abuse = (smp.accel_pos
                      > cfg.abuse_thresholds[ppm_pkg::CFG_W-1:ppm_pkg::RAW_W])
                  && (smp.brake_pres_front
                      > cfg.abuse_thresholds[ppm_pkg::RAW_W-1:0]);
    end

endmodule

FILE: rtl/core/ppm_persist.sv
module ppm_persist (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      active,
    input  logic                      cond,
    input  logic [ppm_pkg::CNT_W-1:0] limit,
    output logic                      trip
);

    logic [ppm_pkg::CNT_W-1:0] count_reg;
    logic [ppm_pkg::CNT_W-1:0] count_next;
    logic [ppm_pkg::CNT_W:0]   incr;

    // The increment is one bit wider so that a limit at full scale never wraps.
    always_comb
    begin
        incr       = {1'b0, count_reg} + {{ppm_pkg::CNT_W{1'b0}}, 1'b1};
        trip       = 1'b0;
        count_next = count_reg;
        if (active)
        begin
            if (!cond)
            begin
                count_next = '0;
            end
            else if (incr > {1'b0, limit})
            begin
                count_next = limit;
                trip       = 1'b1;
            end
            else
            begin
                count_next = incr[ppm_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/pedal_plausibility_monitor.sv
// A sample word is checked in the input register and its result word is offered
// from the result register. Throughput: one sample word per cycle while the
// result side does not stall; input and result registers form a two-stage
// pipeline, so result stall reaches the sample side only once both stages are full.
// Reset: configuration returns to its defaults, all persistence counters and
// sticky faults clear, and both pipeline stages empty.
module pedal_plausibility_monitor (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  ppm_pkg::sample_t          sample,
    output logic                      result_valid,
    input  logic                      result_stall,
    output ppm_pkg::result_t          result,
    input  logic                      cfg_we,
    input  logic [ppm_pkg::IDX_W-1:0] cfg_index,
    input  logic [ppm_pkg::CFG_W-1:0] cfg_data
);

    ppm_pkg::cfg_t    cfg;
    ppm_pkg::cond_t   cond;
    ppm_pkg::sample_t smp_reg;
    logic             smp_valid_reg;
    logic             smp_valid_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    ppm_pkg::result_t res_reg;
    logic [ppm_pkg::FLT_W-1:0] sticky_reg;
    logic [ppm_pkg::FLT_W-1:0] sticky_next;
    logic [ppm_pkg::FLT_W-1:0] trip;
    logic             advance;
    logic             take;

    ppm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppm_check u_check (
        .smp  (smp_reg),
        .cfg  (cfg),
        .cond (cond)
    );

    ppm_persist u_accel_range (
        .clk (clk), .rst_n (rst_n), .advance (advance), .active (1'b1),
        .cond (cond.accel_range), .limit (cfg.persist_limit),
        .trip (trip[ppm_pkg::FLT_ACCEL_RANGE])
    );

    ppm_persist u_accel_diff (
        .clk (clk), .rst_n (rst_n), .advance (advance), .active (1'b1),
        .cond (cond.accel_diff), .limit (cfg.persist_limit),
        .trip (trip[ppm_pkg::FLT_ACCEL_DIFF])
    );

    ppm_persist u_brake_range (
        .clk (clk), .rst_n (rst_n), .advance (advance), .active (1'b1),
        .cond (cond.brake_range), .limit (cfg.persist_limit),
        .trip (trip[ppm_pkg::FLT_BRAKE_RANGE])
    );

    // With the abuse check switched off its counter neither counts nor clears.
    ppm_persist u_abuse (
        .clk (clk), .rst_n (rst_n), .advance (advance),
        .active (cfg.abuse_check_on),
        .cond (cond.abuse), .limit (cfg.persist_limit),
        .trip (trip[ppm_pkg::FLT_ABUSE])
    );

    always_comb
    begin
        advance        = smp_valid_reg && (!res_valid_reg || !result_stall);
        sample_stall   = smp_valid_reg && !advance;
        take           = sample_valid && !sample_stall;
        smp_valid_next = take || (smp_valid_reg && !advance);
        res_valid_next = advance || (res_valid_reg && result_stall);
        sticky_next    = sticky_reg | trip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            sticky_reg    <= '0;
        end
        else
        begin
            smp_valid_reg <= smp_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                sticky_reg <= sticky_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            smp_reg <= sample;
        end
        if (advance)
        begin
            res_reg.fault_flags  <= sticky_next;
            res_reg.fault_status <= |sticky_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

FILE: rtl/core/ppm_checker.sv
module ppm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input logic             result_valid,
    input logic             result_stall,
    input ppm_pkg::result_t result
);

    logic [1:0]                outstanding_reg;
    logic [1:0]                outstanding_next;
    logic [ppm_pkg::FLT_W-1:0] last_flags_reg;
    logic                      in_take;
    logic                      out_take;

    always_comb
    begin
        in_take          = sample_valid && !sample_stall;
        out_take         = result_valid && !result_stall;
        outstanding_next = outstanding_reg + {1'b0, in_take} - {1'b0, out_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            last_flags_reg  <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
            if (out_take)
            begin
                last_flags_reg <= result.fault_flags;
            end
        end
    end

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.fault_status == (|result.fault_flags))
        else $error("fault status disagrees with fault flags");

    // Faults are sticky: no delivered flag may later vanish.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.fault_flags & last_flags_reg) == last_flags_reg)
        else $error("sticky fault cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> outstanding_reg != 2'd0)
        else $error("result word with no sample word taken");

    // With both stages full and the result side stalled, nothing more can enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 2'd2 && result_stall |-> sample_stall)
        else $error("sample word taken with both stages full");

endmodule

bind pedal_plausibility_monitor ppm_checker u_ppm_checker (.*);
